// ===== sv/fuir_pkg.sv =====
`default_nettype none

package fuir_pkg;

  // Field widths
  localparam int IDX_W   = 12;
  localparam int CNT_W   = 13;
  localparam int CFG_IDX_W = 2;

  // Attribute lanes: position, normal, texture coordinate
  localparam int LANES = 3;

  // Default table depth
  localparam int TABLE_DEPTH_DEF = 4096;

  // Commands
  localparam logic CMD_RENUMBER = 1'b0;
  localparam logic CMD_CLEAR    = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_TOTAL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_TOTAL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_UV_TOTAL     = 2'd2;

  // One map entry: assigned mark and compact index
  typedef struct packed {
    logic             assigned;
    logic [IDX_W-1:0] value;
  } entry_t;

endpackage

`default_nettype wire

// ===== sv/first_use_index_renumbering.sv =====
// An accepted corner beat is registered in the lookup stage with its map reads,
// then in the result register. One corner per cycle while the result register
// is free or being taken, set by the map read / write-back loop (registered memory
// read, last write forwarded to the following corner). A clear command, and every
// reset, starts a clearing pass over all TABLE_DEPTH entries of the three maps; no corner is accepted during the pass.
// Reset is synchronous and active high; totals and counters reset to zero.
`default_nettype none

module first_use_index_renumbering #(
  parameter int TABLE_DEPTH = fuir_pkg::TABLE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // configuration
  input  logic                           cfg_write,
  input  logic [fuir_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fuir_pkg::CNT_W-1:0]     cfg_data,
  // corner input
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           cmd,
  input  logic [fuir_pkg::IDX_W-1:0]     position_index,
  input  logic                           has_normal,
  input  logic [fuir_pkg::IDX_W-1:0]     normal_index,
  input  logic                           has_uv,
  input  logic [fuir_pkg::IDX_W-1:0]     uv_index,
  // result output
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [fuir_pkg::IDX_W-1:0]     new_position,
  output logic                           new_normal_valid,
  output logic [fuir_pkg::IDX_W-1:0]     new_normal,
  output logic                           new_uv_valid,
  output logic [fuir_pkg::IDX_W-1:0]     new_uv,
  output logic                           first_position,
  output logic                           first_normal,
  output logic                           first_uv,
  output logic                           index_error,
  output logic [fuir_pkg::CNT_W-1:0]     position_count,
  output logic [fuir_pkg::CNT_W-1:0]     normal_count,
  output logic [fuir_pkg::CNT_W-1:0]     uv_count
);

  localparam int LANES = fuir_pkg::LANES;
  localparam int IDX_W = fuir_pkg::IDX_W;
  localparam int CNT_W = fuir_pkg::CNT_W;
  localparam int AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int XW    = (AW > IDX_W) ? AW : IDX_W;

  typedef enum logic [1:0] {
    ST_RUN   = 2'b01,
    ST_CLEAR = 2'b10
  } state_t;

  state_t state;
  logic [AW-1:0] clear_addr;
  logic clearing;

  logic [CNT_W-1:0] cfg_total [LANES];

  // input lanes
  logic [IDX_W-1:0] in_idx  [LANES];
  logic [LANES-1:0] in_has;
  logic [XW-1:0]    idx_x   [LANES];
  logic [AW-1:0]    in_addr [LANES];
  logic             in_bad;
  logic             in_fire;

  // lookup stage
  logic             s1_valid;
  logic             s1_cmd;
  logic             s1_err;
  logic [LANES-1:0] s1_has;
  logic [AW-1:0]    s1_addr [LANES];
  logic             s1_adv;

  // maps and forwarding
  fuir_pkg::entry_t rdata    [LANES];
  fuir_pkg::entry_t ent      [LANES];
  fuir_pkg::entry_t fwd_data [LANES];
  logic [AW-1:0]    fwd_addr [LANES];
  logic [LANES-1:0] fwd_valid;
  logic [LANES-1:0] mem_we;
  logic [AW-1:0]    mem_wa   [LANES];
  fuir_pkg::entry_t mem_wd   [LANES];

  // per-lane results
  logic [LANES-1:0] take;
  logic [LANES-1:0] first;
  logic [LANES-1:0] lane_wr;
  logic [IDX_W-1:0] val      [LANES];
  logic [CNT_W-1:0] counter  [LANES];
  logic [CNT_W-1:0] cnt_next [LANES];

  assign clearing = (state == ST_CLEAR);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int g = 0; g < LANES; g++) cfg_total[g] <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        fuir_pkg::CFG_VERTEX_TOTAL: cfg_total[0] <= cfg_data;
        fuir_pkg::CFG_NORMAL_TOTAL: cfg_total[1] <= cfg_data;
        fuir_pkg::CFG_UV_TOTAL:     cfg_total[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // input lanes and range check
  always_comb begin
    in_idx[0] = position_index;
    in_idx[1] = normal_index;
    in_idx[2] = uv_index;
    in_has    = {has_uv, has_normal, 1'b1};
    in_bad    = 1'b0;
    for (int g = 0; g < LANES; g++) begin
      idx_x[g]   = XW'(in_idx[g]);
      in_addr[g] = idx_x[g][AW-1:0];
      if (in_has[g] && !((CNT_W'(in_idx[g]) < cfg_total[g]) &&
                         ({1'b0, idx_x[g]} < (XW + 1)'(TABLE_DEPTH)))) begin
        in_bad = 1'b1;
      end
    end
  end

  // stage advances when the output register is free or being taken
  assign s1_adv   = s1_valid && (!out_valid || out_ready);
  assign in_ready = !clearing && !(s1_valid && s1_cmd == fuir_pkg::CMD_CLEAR) &&
                    (!s1_valid || s1_adv);
  assign in_fire  = in_valid && in_ready;

  // lookup, first-use decision and write-back
  always_comb begin
    for (int g = 0; g < LANES; g++) begin
      ent[g] = (fwd_valid[g] && fwd_addr[g] == s1_addr[g]) ? fwd_data[g] : rdata[g];
      take[g]  = !s1_err && s1_cmd == fuir_pkg::CMD_RENUMBER && s1_has[g];
      first[g] = take[g] && !ent[g].assigned;
      if (!take[g]) val[g] = '0;
      else if (first[g]) val[g] = counter[g][IDX_W-1:0];
      else val[g] = ent[g].value;
      cnt_next[g] = first[g] ? counter[g] + CNT_W'(1) : counter[g];
      lane_wr[g]  = s1_adv && first[g];
      mem_we[g]   = clearing || lane_wr[g];
      mem_wa[g]   = clearing ? clear_addr : s1_addr[g];
      mem_wd[g]   = clearing ? '0 : {1'b1, counter[g][IDX_W-1:0]};
    end
  end

  // one map memory per lane
  for (genvar g = 0; g < LANES; g++) begin : g_map
    fuir_pkg::entry_t mem [TABLE_DEPTH];

    always_ff @(posedge clk) begin
      if (mem_we[g]) mem[mem_wa[g]] <= mem_wd[g];
      if (in_fire) rdata[g] <= mem[in_addr[g]];
    end
  end

  // control: clearing pass, stage valids, counters, forwarding marks
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clear_addr <= '0;
      s1_valid   <= 1'b0;
      out_valid  <= 1'b0;
      fwd_valid  <= '0;
      for (int g = 0; g < LANES; g++) counter[g] <= '0;
    end else begin
      unique case (state)
        ST_CLEAR: begin
          clear_addr <= clear_addr + AW'(1);
          if (clear_addr == AW'(TABLE_DEPTH - 1)) state <= ST_RUN;
        end
        ST_RUN: begin
          if (s1_adv && s1_cmd == fuir_pkg::CMD_CLEAR) begin
            state      <= ST_CLEAR;
            clear_addr <= '0;
          end
        end
        default: state <= ST_CLEAR;
      endcase

      if (in_fire) s1_valid <= 1'b1;
      else if (s1_adv) s1_valid <= 1'b0;

      if (s1_adv) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;

      if (s1_adv && s1_cmd == fuir_pkg::CMD_CLEAR) begin
        fwd_valid <= '0;
        for (int g = 0; g < LANES; g++) counter[g] <= '0;
      end else if (s1_adv) begin
        for (int g = 0; g < LANES; g++) begin
          counter[g] <= cnt_next[g];
          if (lane_wr[g]) fwd_valid[g] <= 1'b1;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_cmd <= cmd;
      s1_err <= in_bad;
      s1_has <= in_has;
      for (int g = 0; g < LANES; g++) s1_addr[g] <= in_addr[g];
    end
    for (int g = 0; g < LANES; g++) begin
      if (lane_wr[g]) begin
        fwd_addr[g] <= s1_addr[g];
        fwd_data[g] <= mem_wd[g];
      end
    end
    if (s1_adv) begin
      new_position     <= val[0];
      new_normal_valid <= take[1];
      new_normal       <= val[1];
      new_uv_valid     <= take[2];
      new_uv           <= val[2];
      first_position   <= first[0];
      first_normal     <= first[1];
      first_uv         <= first[2];
      index_error      <= (s1_cmd == fuir_pkg::CMD_RENUMBER) && s1_err;
      if (s1_cmd == fuir_pkg::CMD_CLEAR) begin
        position_count <= '0;
        normal_count   <= '0;
        uv_count       <= '0;
      end else begin
        position_count <= cnt_next[0];
        normal_count   <= cnt_next[1];
        uv_count       <= cnt_next[2];
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/fuir_checker.sv =====
`default_nettype none

module fuir_checker (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           in_ready,
  input wire logic                           out_valid,
  input wire logic                           out_ready,
  input wire logic [fuir_pkg::IDX_W-1:0]     new_position,
  input wire logic                           new_normal_valid,
  input wire logic [fuir_pkg::IDX_W-1:0]     new_normal,
  input wire logic                           first_position,
  input wire logic                           first_normal,
  input wire logic                           first_uv,
  input wire logic                           index_error,
  input wire logic [fuir_pkg::CNT_W-1:0]     position_count
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(new_position) &&
      $stable(position_count) && $stable(index_error))
    else $error("result beat changed while stalled");

  // reset starts a clearing pass: no corner taken right after
  a_reset_clear: assert property (@(posedge clk) rst |=> !in_ready)
    else $error("corner accepted right after reset");

  // a rejected corner carries no renumbering
  a_error_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && index_error |-> new_position == '0 && !new_normal_valid &&
      !first_position && !first_normal && !first_uv)
    else $error("index error with renumbered fields");

  // an absent normal reads as zero
  a_normal_absent: assert property (@(posedge clk) disable iff (rst)
    out_valid && !new_normal_valid |-> new_normal == '0 && !first_normal)
    else $error("absent normal with nonzero fields");

  // a new position takes the count just before this corner
  a_first_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid && first_position |->
      new_position == fuir_pkg::IDX_W'(position_count - fuir_pkg::CNT_W'(1)))
    else $error("first-use position not the previous count");

endmodule

bind first_use_index_renumbering fuir_checker u_fuir_checker (.*);

`default_nettype wire

// ===== verif/tb_first_use_index_renumbering.sv =====
`default_nettype none

module tb_first_use_index_renumbering;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDX_W           = fuir_pkg::IDX_W;
  localparam int CNT_W           = fuir_pkg::CNT_W;
  localparam int CFG_IDX_W       = fuir_pkg::CFG_IDX_W;
  localparam int LANES           = fuir_pkg::LANES;
  localparam int TABLE_DEPTH_DEF = fuir_pkg::TABLE_DEPTH_DEF;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 190;
  localparam int STEADY_PHASE = 4;
  localparam int REPORT_CAP  = 200;

  // Totals per random phase; the last phase draws its own
  localparam int PHASE_TOTALS [PHASES][3] = '{
    '{4096, 4096, 4096},
    '{64, 16, 8},
    '{1, 4096, 0},
    '{4096, 1, 100},
    '{300, 300, 300},
    '{4000, 20, 4096},
    '{2, 2, 2},
    '{0, 0, 0}
  };

  typedef struct packed {
    logic             cmd;
    logic [IDX_W-1:0] position_index;
    logic             has_normal;
    logic [IDX_W-1:0] normal_index;
    logic             has_uv;
    logic [IDX_W-1:0] uv_index;
  } corner_t;

  typedef struct packed {
    logic [IDX_W-1:0] new_position;
    logic             new_normal_valid;
    logic [IDX_W-1:0] new_normal;
    logic             new_uv_valid;
    logic [IDX_W-1:0] new_uv;
    logic             first_position;
    logic             first_normal;
    logic             first_uv;
    logic             index_error;
    logic [CNT_W-1:0] position_count;
    logic [CNT_W-1:0] normal_count;
    logic [CNT_W-1:0] uv_count;
  } result_t;

  typedef enum logic {ROW_TOTALS, ROW_CORNER} row_kind_t;

  typedef struct {
    row_kind_t        kind;
    logic [CNT_W-1:0] vertex_total;
    logic [CNT_W-1:0] normal_total;
    logic [CNT_W-1:0] uv_total;
    corner_t          corner;
    bit               typed;
    result_t          want;
  } plan_row_t;

  localparam int POS_LANE = 0;
  localparam int NRM_LANE = 1;
  localparam int UV_LANE  = 2;

  // DUT ports
  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = fuir_pkg::CFG_VERTEX_TOTAL;
  logic [CNT_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 cmd = fuir_pkg::CMD_RENUMBER;
  logic [IDX_W-1:0]     position_index = '0;
  logic                 has_normal = 1'b0;
  logic [IDX_W-1:0]     normal_index = '0;
  logic                 has_uv = 1'b0;
  logic [IDX_W-1:0]     uv_index = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [IDX_W-1:0]     new_position;
  logic                 new_normal_valid;
  logic [IDX_W-1:0]     new_normal;
  logic                 new_uv_valid;
  logic [IDX_W-1:0]     new_uv;
  logic                 first_position;
  logic                 first_normal;
  logic                 first_uv;
  logic                 index_error;
  logic [CNT_W-1:0]     position_count;
  logic [CNT_W-1:0]     normal_count;
  logic [CNT_W-1:0]     uv_count;

  // Mirror of the renumbering state
  bit               is_assigned [LANES][TABLE_DEPTH_DEF];
  logic [CNT_W-1:0] compact_of  [LANES][TABLE_DEPTH_DEF];
  logic [CNT_W-1:0] next_compact [LANES];
  logic [CNT_W-1:0] vertex_limit = '0;
  logic [CNT_W-1:0] normal_limit = '0;
  logic [CNT_W-1:0] uv_limit = '0;

  result_t   renumber_due [$];
  plan_row_t plan [$];
  int        errors = 0;
  int        cycles = 0;
  bit        steady = 1'b0;

  first_use_index_renumbering dut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic void clear_maps();
    for (int lane = 0; lane < LANES; lane++) begin
      next_compact[lane] = '0;
      for (int k = 0; k < TABLE_DEPTH_DEF; k++) is_assigned[lane][k] = 1'b0;
    end
  endfunction

  // Look up one source index; an unseen one takes the lane's next number
  function automatic logic [IDX_W-1:0] take_index(int lane, logic [IDX_W-1:0] idx,
                                                  output logic first);
    if (!is_assigned[lane][idx]) begin
      is_assigned[lane][idx] = 1'b1;
      compact_of[lane][idx]  = next_compact[lane];
      next_compact[lane]     = next_compact[lane] + CNT_W'(1);
      first = 1'b1;
    end else begin
      first = 1'b0;
    end
    return compact_of[lane][idx][IDX_W-1:0];
  endfunction

  function automatic result_t renumber_corner(corner_t c);
    result_t r = '0;
    bit      bad;
    if (c.cmd == fuir_pkg::CMD_CLEAR) begin
      clear_maps();
      return r;
    end
    // index must sit below its total; absent attributes are not checked
    bad = (c.position_index >= vertex_limit) ||
          (c.has_normal && c.normal_index >= normal_limit) ||
          (c.has_uv && c.uv_index >= uv_limit);
    if (bad) begin
      r.index_error = 1'b1;
    end else begin
      r.new_position = take_index(POS_LANE, c.position_index, r.first_position);
      if (c.has_normal) begin
        r.new_normal_valid = 1'b1;
        r.new_normal = take_index(NRM_LANE, c.normal_index, r.first_normal);
      end
      if (c.has_uv) begin
        r.new_uv_valid = 1'b1;
        r.new_uv = take_index(UV_LANE, c.uv_index, r.first_uv);
      end
    end
    r.position_count = next_compact[POS_LANE];
    r.normal_count   = next_compact[NRM_LANE];
    r.uv_count       = next_compact[UV_LANE];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic corner_t corner_of(logic c, int p, int hn, int n, int hu, int u);
    corner_t k;
    k.cmd = c;
    k.position_index = p[IDX_W-1:0];
    k.has_normal = hn[0];
    k.normal_index = n[IDX_W-1:0];
    k.has_uv = hu[0];
    k.uv_index = u[IDX_W-1:0];
    return k;
  endfunction

  function automatic result_t result_of(int np, int nnv, int nn, int nuv, int nu,
                                        int fp, int fn, int fu, int err,
                                        int pc, int nc, int uc);
    result_t r;
    r.new_position = np[IDX_W-1:0];
    r.new_normal_valid = nnv[0];
    r.new_normal = nn[IDX_W-1:0];
    r.new_uv_valid = nuv[0];
    r.new_uv = nu[IDX_W-1:0];
    r.first_position = fp[0];
    r.first_normal = fn[0];
    r.first_uv = fu[0];
    r.index_error = err[0];
    r.position_count = pc[CNT_W-1:0];
    r.normal_count = nc[CNT_W-1:0];
    r.uv_count = uc[CNT_W-1:0];
    return r;
  endfunction

  function automatic plan_row_t totals_row(int v, int n, int u);
    plan_row_t r;
    r.kind = ROW_TOTALS;
    r.vertex_total = v[CNT_W-1:0];
    r.normal_total = n[CNT_W-1:0];
    r.uv_total = u[CNT_W-1:0];
    r.corner = '0;
    r.typed = 1'b0;
    r.want = '0;
    return r;
  endfunction

  function automatic plan_row_t corner_row(corner_t c, bit typed, result_t want);
    plan_row_t r;
    r.kind = ROW_CORNER;
    r.vertex_total = '0;
    r.normal_total = '0;
    r.uv_total = '0;
    r.corner = c;
    r.typed = typed;
    r.want = want;
    return r;
  endfunction

  // Append one row to the stimulus table
  function automatic void add_row(plan_row_t r);
    plan = {plan, r};
  endfunction

  // Append one result to the outstanding list
  function automatic void add_due(result_t r);
    renumber_due = {renumber_due, r};
  endfunction

  // Mostly a small hot window so entries get reused; some wide and some out of range
  function automatic logic [IDX_W-1:0] pick_index(logic [CNT_W-1:0] limit);
    int roll;
    int hot;
    roll = $urandom_range(0, 99);
    hot = (limit < 24) ? int'(limit) : 24;
    if (limit == 0 || roll < 8) return IDX_W'($urandom);
    if (roll < 65) return IDX_W'($urandom_range(0, hot - 1));
    return IDX_W'($urandom_range(0, int'(limit) - 1));
  endfunction

  function automatic corner_t random_corner();
    corner_t c;
    c.cmd = ($urandom_range(0, 99) == 0) ? fuir_pkg::CMD_CLEAR : fuir_pkg::CMD_RENUMBER;
    c.has_normal = ($urandom_range(0, 9) < 7);
    c.has_uv = ($urandom_range(0, 9) < 7);
    c.position_index = pick_index(vertex_limit);
    c.normal_index = c.has_normal ? pick_index(normal_limit) : IDX_W'($urandom);
    c.uv_index = c.has_uv ? pick_index(uv_limit) : IDX_W'($urandom);
    return c;
  endfunction

  // Present one corner beat, hold it until accepted, then predict its result
  task automatic send_corner(input corner_t c, output result_t predicted);
    while (!steady && $urandom_range(0, 99) < 13) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    cmd            <= c.cmd;
    position_index <= c.position_index;
    has_normal     <= c.has_normal;
    normal_index   <= c.normal_index;
    has_uv         <= c.has_uv;
    uv_index       <= c.uv_index;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = renumber_corner(c);
  endtask

  // Drain: stop sending, wait for every result, then cover the result latency
  task automatic settle();
    in_valid <= 1'b0;
    while (renumber_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_totals(logic [CNT_W-1:0] v, logic [CNT_W-1:0] n,
                              logic [CNT_W-1:0] u);
    cfg_write <= 1'b1;
    cfg_index <= fuir_pkg::CFG_VERTEX_TOTAL;
    cfg_data  <= v;
    @(posedge clk);
    cfg_index <= fuir_pkg::CFG_NORMAL_TOTAL;
    cfg_data  <= n;
    @(posedge clk);
    cfg_index <= fuir_pkg::CFG_UV_TOTAL;
    cfg_data  <= u;
    @(posedge clk);
    cfg_write <= 1'b0;
    vertex_limit = v;
    normal_limit = n;
    uv_limit     = u;
  endtask

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      errors++;
      if (errors <= REPORT_CAP)
        $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
    end
  endtask

  task automatic check_beat();
    result_t got;
    result_t want;
    got.new_position = new_position;
    got.new_normal_valid = new_normal_valid;
    got.new_normal = new_normal;
    got.new_uv_valid = new_uv_valid;
    got.new_uv = new_uv;
    got.first_position = first_position;
    got.first_normal = first_normal;
    got.first_uv = first_uv;
    got.index_error = index_error;
    got.position_count = position_count;
    got.normal_count = normal_count;
    got.uv_count = uv_count;
    if (renumber_due.size() == 0) begin
      errors++;
      if (errors <= REPORT_CAP)
        $display("%0t: result beat with nothing outstanding", $time);
      return;
    end
    want = renumber_due.pop_front();
    check_field("new_position", 32'(want.new_position), 32'(got.new_position));
    check_field("new_normal_valid", 32'(want.new_normal_valid),
                32'(got.new_normal_valid));
    check_field("new_normal", 32'(want.new_normal), 32'(got.new_normal));
    check_field("new_uv_valid", 32'(want.new_uv_valid), 32'(got.new_uv_valid));
    check_field("new_uv", 32'(want.new_uv), 32'(got.new_uv));
    check_field("first_position", 32'(want.first_position), 32'(got.first_position));
    check_field("first_normal", 32'(want.first_normal), 32'(got.first_normal));
    check_field("first_uv", 32'(want.first_uv), 32'(got.first_uv));
    check_field("index_error", 32'(want.index_error), 32'(got.index_error));
    check_field("position_count", 32'(want.position_count), 32'(got.position_count));
    check_field("normal_count", 32'(want.normal_count), 32'(got.normal_count));
    check_field("uv_count", 32'(want.uv_count), 32'(got.uv_count));
  endtask

  // Receiver: sample result beats at the edge, stall at random, watch the limit
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
      if (out_valid && out_ready) check_beat();
      out_ready <= steady || ($urandom_range(0, 99) >= 13);
    end
    $display("tb_first_use_index_renumbering: errors");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Directed plan, then random phases
  // ---------------------------------------------------------------------------
  initial begin
    result_t predicted;

    // totals at the extremes and one short, then first use and reuse
    add_row(totals_row(4096, 4096, 5));
    add_row(corner_row(corner_of(fuir_pkg::CMD_RENUMBER, 0, 0, 0, 0, 0), 1'b1,
                       result_of(0, 0, 0, 0, 0, 1, 0, 0, 0, 1, 0, 0)));
    add_row(corner_row(corner_of(fuir_pkg::CMD_RENUMBER, 4095, 1, 4095, 1, 4), 1'b1,
                       result_of(1, 1, 0, 1, 0, 1, 1, 1, 0, 2, 1, 1)));
    add_row(corner_row(corner_of(fuir_pkg::CMD_RENUMBER, 0, 1, 4095, 1, 4), 1'b1,
                       result_of(0, 1, 0, 1, 0, 0, 0, 0, 0, 2, 1, 1)));
    // absent attributes ignore their index, even one out of range
    add_row(corner_row(corner_of(fuir_pkg::CMD_RENUMBER, 2730, 0, 4095, 0, 4095), 1'b1,
                       result_of(2, 0, 0, 0, 0, 1, 0, 0, 0, 3, 1, 1)));
    // uv index at its total: error, nothing assigned
    add_row(corner_row(corner_of(fuir_pkg::CMD_RENUMBER, 1365, 1, 1365, 1, 5), 1'b1,
                       result_of(0, 0, 0, 0, 0, 0, 0, 0, 1, 3, 1, 1)));
    add_row(corner_row(corner_of(fuir_pkg::CMD_RENUMBER, 1365, 1, 2730, 1, 0), 1'b1,
                       result_of(3, 1, 1, 1, 1, 1, 1, 1, 0, 4, 2, 2)));
    // clear ignores the other fields
    add_row(corner_row(corner_of(fuir_pkg::CMD_CLEAR, 4095, 1, 4095, 1, 4095), 1'b1,
                       result_of(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0)));
    // zero totals: every corner errors
    add_row(totals_row(0, 0, 0));
    add_row(corner_row(corner_of(fuir_pkg::CMD_RENUMBER, 0, 0, 0, 0, 0), 1'b1,
                       result_of(0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0)));
    add_row(corner_row(corner_of(fuir_pkg::CMD_RENUMBER, 4095, 1, 0, 1, 0), 1'b1,
                       result_of(0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0)));
    add_row(totals_row(1, 4096, 4096));
    add_row(corner_row(corner_of(fuir_pkg::CMD_RENUMBER, 1, 0, 0, 0, 0), 1'b1,
                       result_of(0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0)));
    add_row(corner_row(corner_of(fuir_pkg::CMD_RENUMBER, 0, 1, 4095, 1, 4095), 1'b1,
                       result_of(0, 1, 0, 1, 0, 1, 1, 1, 0, 1, 1, 1)));
    add_row(corner_row(corner_of(fuir_pkg::CMD_RENUMBER, 0, 1, 7, 0, 4095), 1'b1,
                       result_of(0, 1, 1, 0, 0, 0, 1, 0, 0, 1, 2, 1)));
    // shrunken normal total hides an assigned entry until raised again
    add_row(totals_row(1, 4, 4096));
    add_row(corner_row(corner_of(fuir_pkg::CMD_RENUMBER, 0, 1, 7, 0, 0), 1'b1,
                       result_of(0, 0, 0, 0, 0, 0, 0, 0, 1, 1, 2, 1)));
    add_row(corner_row(corner_of(fuir_pkg::CMD_RENUMBER, 0, 0, 7, 1, 4095), 1'b1,
                       result_of(0, 0, 0, 1, 0, 0, 0, 0, 0, 1, 2, 1)));
    add_row(totals_row(1, 4096, 4096));
    add_row(corner_row(corner_of(fuir_pkg::CMD_RENUMBER, 0, 1, 7, 0, 0), 1'b1,
                       result_of(0, 1, 1, 0, 0, 0, 0, 0, 0, 1, 2, 1)));
    add_row(corner_row(corner_of(fuir_pkg::CMD_RENUMBER, 0, 1, 3, 1, 3), 1'b0, '0));
    add_row(corner_row(corner_of(fuir_pkg::CMD_RENUMBER, 0, 1, 3, 1, 2), 1'b0, '0));

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_TOTALS) begin
        settle();
        write_totals(plan[i].vertex_total, plan[i].normal_total, plan[i].uv_total);
      end else begin
        send_corner(plan[i].corner, predicted);
        add_due(plan[i].typed ? plan[i].want : predicted);
      end
    end

    // Random phases; tables carry over so lowered totals hide old entries
    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      if (ph == PHASES - 1)
        write_totals(CNT_W'($urandom_range(0, 4096)), CNT_W'($urandom_range(0, 4096)),
                     CNT_W'($urandom_range(0, 4096)));
      else
        write_totals(CNT_W'(PHASE_TOTALS[ph][0]), CNT_W'(PHASE_TOTALS[ph][1]),
                     CNT_W'(PHASE_TOTALS[ph][2]));
      steady = (ph == STEADY_PHASE);
      repeat (PHASE_ITEMS) begin
        send_corner(random_corner(), predicted);
        add_due(predicted);
      end
    end
    steady = 1'b0;

    settle();
    if (errors == 0)
      $display("tb_first_use_index_renumbering: clean");
    else
      $display("tb_first_use_index_renumbering: errors");
    $finish;
  end

endmodule

`default_nettype wire

// ===== first_use_index_renumbering.f =====
sv/fuir_pkg.sv
sv/first_use_index_renumbering.sv
sv/fuir_checker.sv
verif/tb_first_use_index_renumbering.sv
